@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL of the SLIP response frame parser.
// Define SYNTH to compile the checks away; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define SRFP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition must never be true outside reset.
`define SRFP_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define SRFP_ASSERT(label, clk, rst, prop, msg)
`define SRFP_NEVER(label, clk, rst, cond, msg)
`endif

`endif

@@ hdl/srfp_pkg.sv @@
// Types and constants for the SLIP response frame parser.
// No dependencies; used by srfp_fifo and slip_response_frame_parser.
package srfp_pkg;

   // SLIP framing bytes
   localparam logic [7:0] SLIP_END     = 8'hC0;
   localparam logic [7:0] SLIP_ESC     = 8'hDB;
   localparam logic [7:0] SLIP_ESC_END = 8'hDC;
   localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

   // item kinds on the input side
   localparam logic FUNC_BYTE = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   // result kinds
   localparam logic [1:0] KIND_DATA = 2'd0;
   localparam logic [1:0] KIND_DONE = 2'd1;
   localparam logic [1:0] KIND_FAIL = 2'd2;

   // error codes
   localparam logic [2:0] ERR_NONE    = 3'd0;
   localparam logic [2:0] ERR_TIMEOUT = 3'd1;
   localparam logic [2:0] ERR_DIR     = 3'd2;
   localparam logic [2:0] ERR_CMD     = 3'd3;
   localparam logic [2:0] ERR_LEN     = 3'd4;

   // register indexes and reset values
   localparam logic CSR_EXPECTED_COMMAND = 1'b0;
   localparam logic CSR_TIMEOUT_TICKS    = 1'b1;
   localparam logic [7:0]  EXPECTED_COMMAND_RST = 8'd8;
   localparam logic [15:0] TIMEOUT_TICKS_RST    = 16'd500;

   // header layout
   localparam logic [3:0]  HDR_BYTES   = 4'd8;
   localparam logic [7:0]  DIR_RESPONSE = 8'd1;
   localparam logic [15:0] MIN_LENGTH  = 16'd4;

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_HEADER,
      PH_PAYLOAD,
      PH_TRAIL
   } phase_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  payload_byte;
      logic [31:0] reply_value;
      logic [15:0] reply_length;
      logic [2:0]  error_code;
      logic        last;
   } result_type;

   function automatic result_type make_result(logic [1:0] kind, logic [7:0] pb,
                                              logic [31:0] val, logic [15:0] len,
                                              logic [2:0] err, logic last);
      result_type r;
      r.kind         = kind;
      r.payload_byte = pb;
      r.reply_value  = val;
      r.reply_length = len;
      r.error_code   = err;
      r.last         = last;
      return r;
   endfunction

endpackage

@@ hdl/slip_response_frame_parser.sv @@
// Top level of the SLIP response frame parser: input register, parser state,
// config registers. Depends on srfp_pkg, srfp_fifo and assert_macros.svh.
//
// Usage:
//  - req_ channel: one beat per received serial byte (tuser = 0, tdata = byte)
//    or per millisecond tick (tuser = 1). Bytes are skipped until an opening
//    0xC0; then an 8-byte SLIP-escaped header is checked, payload bytes stream
//    out, and the closing 0xC0 (or a bad header or timeout) gives the verdict.
//  - rsp_ channel: payload beats (kind 0), then one verdict beat with tlast
//    (kind 1 complete, kind 2 failed with an error code).
//  - csr_ port: write expected_command (index 0) and timeout_ticks (index 1)
//    while the block is idle; a write takes effect at the next edge.
//  - Path: an accepted beat is held in the input register, and its results
//    pass through the result queue before they appear on rsp_.
//  - Throughput: one input beat per cycle unless stalled (see Stall); the parser
//    updates its state once per beat. A beat can yield two results (an invalid
//    escape in the payload); rsp_ drains one beat per cycle under rsp_tready.
//  - Stall: a 4-entry result queue sits before rsp_; the parser works only
//    while the queue has room for two results, else a held beat waits and req_tready drops.
//  - Reset: synchronous, active high; the parser returns to hunting for 0xC0,
//    the queue empties and the registers take 8 and 500.
`include "assert_macros.svh"

module slip_response_frame_parser #(
   parameter int FIFO_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   // input beats
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] func
   // result beats
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [7:0] payload_byte, [39:8] reply_value,
                                    // [55:40] reply_length, [58:56] error_code
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast,   // last
   // configuration writes
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   // config registers
   logic [7:0]  exp_cmd_ff;
   logic [15:0] timeout_ff;

   // input register
   logic        in_valid_ff;
   logic        in_func_ff;
   logic [7:0]  in_byte_ff;
   logic        room2;
   logic        proc_fire;

   // parser state
   srfp_pkg::phase_type phase_ff, phase_in;
   logic        esc_ff, esc_in;
   logic [3:0]  hcnt_ff, hcnt_in;
   logic [63:0] hbits_ff, hbits_in;
   logic [15:0] left_ff, left_in;
   logic [15:0] idle_ff, idle_in;

   // decode and results
   logic [7:0]  dec0, dec1, cur;
   logic [1:0]  ndec;
   logic        stop;
   logic [1:0]  nres;
   logic [2:0]  herr;
   srfp_pkg::result_type res0, res1, new_res, head;
   logic        q_valid;

   assign proc_fire  = in_valid_ff && room2;
   assign req_tready = !in_valid_ff || room2;

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_cmd_ff <= srfp_pkg::EXPECTED_COMMAND_RST;
         timeout_ff <= srfp_pkg::TIMEOUT_TICKS_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            srfp_pkg::CSR_EXPECTED_COMMAND: exp_cmd_ff <= csr_wdata[7:0];
            srfp_pkg::CSR_TIMEOUT_TICKS:    timeout_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_func_ff <= req_tuser;
         in_byte_ff <= req_tdata;
      end
   end

   // one pass per beat: SLIP decode of up to two bytes, header fill and check,
   // payload count, trailing delimiter and tick timeout
   always_comb begin
      phase_in = phase_ff;
      esc_in   = esc_ff;
      hcnt_in  = hcnt_ff;
      hbits_in = hbits_ff;
      left_in  = left_ff;
      idle_in  = idle_ff;
      res0     = '0;
      res1     = '0;
      new_res  = '0;
      nres     = 2'd0;
      dec0     = 8'd0;
      dec1     = 8'd0;
      ndec     = 2'd0;
      cur      = 8'd0;
      stop     = 1'b0;
      herr     = srfp_pkg::ERR_NONE;
      if (proc_fire) begin
         if (in_func_ff == srfp_pkg::FUNC_TICK) begin
            if (phase_ff != srfp_pkg::PH_HUNT) begin
               if (idle_ff >= timeout_ff) begin
                  res0 = srfp_pkg::make_result(srfp_pkg::KIND_FAIL, 8'd0, 32'd0,
                     (phase_ff == srfp_pkg::PH_HEADER) ? 16'd0 : hbits_ff[31:16],
                     srfp_pkg::ERR_TIMEOUT, 1'b1);
                  nres     = 2'd1;
                  phase_in = srfp_pkg::PH_HUNT;
                  esc_in   = 1'b0;
                  hcnt_in  = 4'd0;
                  left_in  = 16'd0;
                  idle_in  = 16'd0;
               end else begin
                  idle_in = idle_ff + 16'd1;
               end
            end
         end else if (phase_ff == srfp_pkg::PH_HUNT) begin
            if (in_byte_ff == srfp_pkg::SLIP_END) begin
               phase_in = srfp_pkg::PH_HEADER;
               esc_in   = 1'b0;
               hcnt_in  = 4'd0;
               left_in  = 16'd0;
               idle_in  = 16'd0;
            end
         end else if (phase_ff == srfp_pkg::PH_TRAIL) begin
            if (in_byte_ff == srfp_pkg::SLIP_END) begin
               res0 = srfp_pkg::make_result(srfp_pkg::KIND_DONE, 8'd0, hbits_ff[63:32],
                  hbits_ff[31:16], srfp_pkg::ERR_NONE, 1'b1);
               nres     = 2'd1;
               phase_in = srfp_pkg::PH_HUNT;
               esc_in   = 1'b0;
               hcnt_in  = 4'd0;
               left_in  = 16'd0;
               idle_in  = 16'd0;
            end
         end else begin
            idle_in = 16'd0;
            // escape decode
            if (esc_ff) begin
               esc_in = 1'b0;
               if (in_byte_ff == srfp_pkg::SLIP_ESC_ESC) begin
                  dec0 = srfp_pkg::SLIP_ESC;
                  ndec = 2'd1;
               end else if (in_byte_ff == srfp_pkg::SLIP_ESC_END) begin
                  dec0 = srfp_pkg::SLIP_END;
                  ndec = 2'd1;
               end else begin
                  // invalid escape: pass DB, then the byte itself
                  dec0 = srfp_pkg::SLIP_ESC;
                  dec1 = in_byte_ff;
                  ndec = 2'd2;
               end
            end else if (in_byte_ff == srfp_pkg::SLIP_ESC) begin
               esc_in = 1'b1;
            end else begin
               dec0 = in_byte_ff;
               ndec = 2'd1;
            end
            for (int i = 0; i < 2; i++) begin
               if (!stop && (2'(i) < ndec)) begin
                  cur = (i == 0) ? dec0 : dec1;
                  if (phase_in == srfp_pkg::PH_HEADER && hcnt_in < srfp_pkg::HDR_BYTES) begin
                     hbits_in[{hcnt_in[2:0], 3'b000} +: 8] = cur;
                     hcnt_in = hcnt_in + 4'd1;
                     if (hcnt_in == srfp_pkg::HDR_BYTES) begin
                        // header check: direction, command, then length
                        if (hbits_in[7:0] != srfp_pkg::DIR_RESPONSE) begin
                           herr = srfp_pkg::ERR_DIR;
                        end else if (hbits_in[15:8] != exp_cmd_ff) begin
                           herr = srfp_pkg::ERR_CMD;
                        end else if (hbits_in[31:16] < srfp_pkg::MIN_LENGTH) begin
                           herr = srfp_pkg::ERR_LEN;
                        end
                        if (herr != srfp_pkg::ERR_NONE) begin
                           new_res = srfp_pkg::make_result(srfp_pkg::KIND_FAIL, 8'd0, 32'd0,
                              hbits_in[31:16], herr, 1'b1);
                           phase_in = srfp_pkg::PH_HUNT;
                           hcnt_in  = 4'd0;
                           left_in  = 16'd0;
                        end else begin
                           phase_in = srfp_pkg::PH_PAYLOAD;
                           left_in  = hbits_in[31:16];
                        end
                        esc_in  = 1'b0;
                        idle_in = 16'd0;
                        stop    = 1'b1;
                     end
                  end else if (phase_in == srfp_pkg::PH_PAYLOAD && left_in != 16'd0) begin
                     new_res = srfp_pkg::make_result(srfp_pkg::KIND_DATA, cur, 32'd0, 16'd0,
                        srfp_pkg::ERR_NONE, 1'b0);
                     left_in = left_in - 16'd1;
                     if (left_in == 16'd0) begin
                        phase_in = srfp_pkg::PH_TRAIL;
                        esc_in   = 1'b0;
                        idle_in  = 16'd0;
                        stop     = 1'b1;
                     end
                  end
                  // slot the result produced by this decoded byte, if any
                  if (new_res.last || (phase_ff == srfp_pkg::PH_PAYLOAD &&
                                       new_res.kind == srfp_pkg::KIND_DATA &&
                                       (phase_in != srfp_pkg::PH_PAYLOAD || left_in != left_ff ||
                                        nres != 2'd0) && (2'(i) >= nres) &&
                                       (left_ff - left_in) > 16'(nres))) begin
                     if (nres == 2'd0) begin
                        res0 = new_res;
                     end else begin
                        res1 = new_res;
                     end
                     nres = nres + 2'd1;
                  end
                  new_res = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= srfp_pkg::PH_HUNT;
         esc_ff   <= 1'b0;
         hcnt_ff  <= 4'd0;
         left_ff  <= 16'd0;
         idle_ff  <= 16'd0;
      end else begin
         phase_ff <= phase_in;
         esc_ff   <= esc_in;
         hcnt_ff  <= hcnt_in;
         left_ff  <= left_in;
         idle_ff  <= idle_in;
      end
   end

   always_ff @(posedge clock) begin
      hbits_ff <= hbits_in;
   end

   srfp_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push0      (nres != 2'd0),
      .push0_data (res0),
      .push1      (nres == 2'd2),
      .push1_data (res1),
      .pop        (rsp_tready),
      .out_valid  (q_valid),
      .out_data   (head),
      .room2      (room2)
   );

   assign rsp_tvalid = q_valid;
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.last;
   assign rsp_tdata  = {5'd0, head.error_code, head.reply_length, head.reply_value,
                        head.payload_byte};

   `SRFP_ASSERT(a_in_hold, clock, reset,
      in_valid_ff && !proc_fire |=> in_valid_ff && $stable(in_byte_ff), "input beat lost")
   `SRFP_ASSERT(a_last_verdict, clock, reset,
      rsp_tvalid |-> rsp_tlast == (rsp_tuser != srfp_pkg::KIND_DATA), "tlast not on verdict")
   `SRFP_ASSERT(a_hunt_clean, clock, reset,
      phase_ff == srfp_pkg::PH_HUNT |-> hcnt_ff == 4'd0 && !esc_ff, "hunt state not clean")
   `SRFP_ASSERT(a_payload_left, clock, reset,
      phase_ff == srfp_pkg::PH_PAYLOAD |-> left_ff != 16'd0, "payload with nothing left")

endmodule

@@ hdl/srfp_fifo.sv @@
// Small result queue: up to two pushes and one pop per cycle.
// Depends on srfp_pkg (result_type) and assert_macros.svh.
`include "assert_macros.svh"

module srfp_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push0,
   input  srfp_pkg::result_type push0_data,
   input  logic                push1,
   input  srfp_pkg::result_type push1_data,
   input  logic                pop,
   output logic                out_valid,
   output srfp_pkg::result_type out_data,
   output logic                room2
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   srfp_pkg::result_type mem_ff [DEPTH];
   logic [AW-1:0] wp_ff, wp_in, wp_plus1, wp_plus2, rp_ff, rp_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          pop_fire;

   assign wp_plus1 = (wp_ff == AW'(DEPTH - 1)) ? '0 : wp_ff + 1'b1;
   assign wp_plus2 = (wp_plus1 == AW'(DEPTH - 1)) ? '0 : wp_plus1 + 1'b1;
   assign pop_fire = pop && (cnt_ff != '0);

   always_comb begin
      wp_in = wp_ff;
      if (push0 && push1) begin
         wp_in = wp_plus2;
      end else if (push0) begin
         wp_in = wp_plus1;
      end
      rp_in = rp_ff;
      if (pop_fire) begin
         rp_in = (rp_ff == AW'(DEPTH - 1)) ? '0 : rp_ff + 1'b1;
      end
      cnt_in = cnt_ff + CW'(push0) + CW'(push1) - CW'(pop_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push0) begin
         mem_ff[wp_ff] <= push0_data;
      end
      if (push0 && push1) begin
         mem_ff[wp_plus1] <= push1_data;
      end
   end

   assign out_valid = (cnt_ff != '0);
   assign out_data  = mem_ff[rp_ff];
   assign room2     = (cnt_ff <= CW'(DEPTH - 2));

   `SRFP_ASSERT(a_push_order, clock, reset, push1 |-> push0, "second push without first")
   `SRFP_NEVER(a_overflow, clock, reset, push0 && push1 && !room2, "queue overflow")
   `SRFP_ASSERT(a_count_bound, clock, reset, cnt_ff <= CW'(DEPTH), "count beyond depth")
   `SRFP_ASSERT(a_pop_count, clock, reset,
      pop_fire && !push0 |=> cnt_ff == $past(cnt_ff) - 1'b1, "pop did not drop count")

endmodule
